FILE: rtl/core/multi_rate_timeout_timer_bank_macros.svh
// Assertion macros shared by the timer bank modules.
`ifndef MULTI_RATE_TIMEOUT_TIMER_BANK_MACROS_SVH
`define MULTI_RATE_TIMEOUT_TIMER_BANK_MACROS_SVH

`ifndef SYNTHESIS
`define MRTT_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer bank check failed");
`define MRTT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank check failed");
`else
`define MRTT_ASSERT_SAME(name, clk, rst, ante, cons)
`define MRTT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/mrtt_pkg.sv
package mrtt_pkg;

  localparam int OBJ_FIELD_W  = 6;
  localparam int RATE_FIELD_W = 2;
  localparam int OP_W         = 2;
  localparam int TICKS_W      = 16;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ARM    = 2'd1;
  localparam logic [OP_W-1:0] OP_DISARM = 2'd2;

  // register index taken from paddr[2]
  localparam logic REG_ACTIVE_COUNT = 1'b0;
  localparam logic [OBJ_FIELD_W-1:0] ACTIVE_COUNT_RESET = 6'd32;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_walk;
    logic rd_en;
    logic step;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic hold;
    logic bottom;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/core/mrtt_ram.sv
module mrtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/mrtt_ctrl.sv
`include "multi_rate_timeout_timer_bank_macros.svh"

module mrtt_ctrl import mrtt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && sts.tick_go) begin
          cmd.load_walk = 1'b1;
          state_next    = ST_START;
        end
      end
      ST_START: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (!sts.hold) begin
          cmd.step = 1'b1;
          if (sts.bottom) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `MRTT_ASSERT_NEXT(a_load_then_read, clk, rst, cmd.load_walk, cmd.rd_en)
  `MRTT_ASSERT_SAME(a_flush_has_slot, clk, rst, cmd.flush, sts.pend_valid && sts.out_free)
  `MRTT_ASSERT_NEXT(a_bottom_ends_walk, clk, rst, cmd.step && sts.bottom, state == ST_FLUSH)

endmodule

FILE: rtl/core/mrtt_dp.sv
`include "multi_rate_timeout_timer_bank_macros.svh"

module mrtt_dp import mrtt_pkg::*; #(
  parameter int MAX_OBJECTS = 32,
  parameter int RATE_COUNT  = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [OBJ_FIELD_W-1:0]  active_count,
  input  logic [OP_W-1:0]         op,
  input  logic [OBJ_FIELD_W-1:0]  object_index,
  input  logic [RATE_FIELD_W-1:0] rate_index,
  input  logic [TICKS_W-1:0]      start_ticks,
  input  logic [TICKS_W-1:0]      period_ticks,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              sts,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OBJ_FIELD_W-1:0]  expired_object,
  output logic [RATE_FIELD_W-1:0] expired_rate,
  output logic                    last
);

  localparam int OBJ_W  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int RATE_W = (RATE_COUNT > 1) ? $clog2(RATE_COUNT) : 1;
  localparam int ADDR_W = RATE_W + OBJ_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int WORD_W = 2 * COUNT_WIDTH;

  logic [OBJ_FIELD_W-1:0]  p;
  logic [RATE_FIELD_W-1:0] walk_rate;
  logic [OBJ_FIELD_W-1:0]  pend_obj;
  logic                    pend_valid;
  logic [DEPTH-1:0]        vld;
  logic                    rd_vld;

  logic [OBJ_FIELD_W-1:0]  top_obj;
  logic [OBJ_FIELD_W-1:0]  p_m1, p_m2, arm_m1;
  logic                    rate_ok, obj_ok, arm_we;
  logic [ADDR_W-1:0]       cur_addr, nxt_addr, arm_addr;
  logic                    we, re;
  logic [ADDR_W-1:0]       waddr, raddr;
  logic [WORD_W-1:0]       wdata, rdata, rword;
  logic [COUNT_WIDTH-1:0]  rem, per, rem_dec;
  logic                    nonzero, expire, out_free, bottom, emit_mid;

  assign top_obj = (active_count > OBJ_FIELD_W'(MAX_OBJECTS))
                   ? OBJ_FIELD_W'(MAX_OBJECTS) : active_count;
  assign rate_ok = 32'(rate_index) < RATE_COUNT;
  assign obj_ok  = (object_index != '0) && (32'(object_index) <= MAX_OBJECTS);
  assign arm_we  = cmd.accept && rate_ok && obj_ok && ((op == OP_ARM) || (op == OP_DISARM));

  assign p_m1     = p - OBJ_FIELD_W'(1);
  assign p_m2     = p - OBJ_FIELD_W'(2);
  assign arm_m1   = object_index - OBJ_FIELD_W'(1);
  assign cur_addr = {walk_rate[RATE_W-1:0], p_m1[OBJ_W-1:0]};
  assign nxt_addr = {walk_rate[RATE_W-1:0], p_m2[OBJ_W-1:0]};
  assign arm_addr = {rate_index[RATE_W-1:0], arm_m1[OBJ_W-1:0]};
  assign bottom   = (p == OBJ_FIELD_W'(1));

  // Walk evaluation on the word held in the RAM read register
  assign rword   = rd_vld ? rdata : '0;
  assign rem     = rword[COUNT_WIDTH-1:0];
  assign per     = rword[WORD_W-1:COUNT_WIDTH];
  assign nonzero = (rem != '0);
  assign rem_dec = rem - COUNT_WIDTH'(1);
  assign expire  = nonzero && (rem_dec == '0);

  assign out_free = !out_valid || !out_stall;
  assign emit_mid = cmd.step && expire && pend_valid;

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {per, expire ? per : rem_dec};
    if (arm_we) begin
      we    = 1'b1;
      waddr = arm_addr;
      wdata = (op == OP_ARM) ? {COUNT_WIDTH'(period_ticks), COUNT_WIDTH'(start_ticks)} : '0;
    end else if (cmd.step && nonzero) begin
      we = 1'b1;
    end
  end

  assign re    = cmd.rd_en || (cmd.step && !bottom);
  assign raddr = cmd.step ? nxt_addr : cur_addr;

  mrtt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_vld <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_walk) begin
      p         <= top_obj;
      walk_rate <= rate_index;
    end else if (cmd.step) begin
      p <= p_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.step && expire) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && expire) begin
      pend_obj <= p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_mid || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_mid || cmd.flush) begin
      expired_object <= pend_obj;
      expired_rate   <= walk_rate;
      last           <= cmd.flush;
    end
  end

  always_comb begin
    sts            = '0;
    sts.tick_go    = (op == OP_TICK) && rate_ok && (top_obj != '0);
    sts.hold       = expire && pend_valid && !out_free;
    sts.bottom     = bottom;
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

  `MRTT_ASSERT_SAME(a_no_rw_clash, clk, rst, we && re, waddr != raddr)
  `MRTT_ASSERT_SAME(a_pending_kept, clk, rst, emit_mid, out_free)
  `MRTT_ASSERT_SAME(a_walk_nonzero, clk, rst, cmd.step || cmd.rd_en, p != '0)

endmodule

FILE: rtl/core/multi_rate_timeout_timer_bank.sv
// Channel   Handshake            Payload
// in        in_valid / in_stall  op, object_index, rate_index, start_ticks, period_ticks
// out       out_valid / out_stall expired_object, expired_rate, last
// apb       psel/penable/pwrite  paddr, pwdata, prdata, pready (active_count at 0x0)
//
// Arm, disarm and ignored items need no walk, nor does a tick with active_count zero.
// Other tick items walk min(active_count, MAX_OBJECTS) timers top down: one timer per
// cycle through a single RAM read port, with a write-back of the previous timer.
// The walk pauses while a second expiry meets a stalled output register, and the
// final expiry waits in flush until the output register is free.
// Reset clears the per-timer valid flags at once, so no clearing pass follows it.
module multi_rate_timeout_timer_bank import mrtt_pkg::*; #(
  parameter int MAX_OBJECTS = 32,
  parameter int RATE_COUNT  = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         op,
  input  logic [OBJ_FIELD_W-1:0]  object_index,
  input  logic [RATE_FIELD_W-1:0] rate_index,
  input  logic [TICKS_W-1:0]      start_ticks,
  input  logic [TICKS_W-1:0]      period_ticks,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OBJ_FIELD_W-1:0]  expired_object,
  output logic [RATE_FIELD_W-1:0] expired_rate,
  output logic                    last,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready
);

  logic [OBJ_FIELD_W-1:0] active_count;
  ctrl_cmd_t              cmd;
  dp_status_t             sts;
  logic                   busy;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= ACTIVE_COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE_COUNT)) begin
      active_count <= pwdata[OBJ_FIELD_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ACTIVE_COUNT) ? APB_DATA_W'(active_count) : '0;

  assign in_stall = busy;

  mrtt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  mrtt_dp #(
    .MAX_OBJECTS(MAX_OBJECTS),
    .RATE_COUNT (RATE_COUNT),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .active_count  (active_count),
    .op            (op),
    .object_index  (object_index),
    .rate_index    (rate_index),
    .start_ticks   (start_ticks),
    .period_ticks  (period_ticks),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .expired_object(expired_object),
    .expired_rate  (expired_rate),
    .last          (last)
  );

endmodule

FILE: dv/multi_rate_timeout_timer_bank_tb.sv
module multi_rate_timeout_timer_bank_tb;
  import mrtt_pkg::*;

  localparam int OBJECTS = 32;
  localparam int RATES = 4;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [OBJ_FIELD_W-1:0]  obj;
    logic [RATE_FIELD_W-1:0] rate;
    logic [TICKS_W-1:0]      start;
    logic [TICKS_W-1:0]      period;
  } timer_item_t;

  typedef struct packed {
    logic [OBJ_FIELD_W-1:0]  obj;
    logic [RATE_FIELD_W-1:0] rate;
    logic                    last;
  } expiry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         op = OP_TICK;
  logic [OBJ_FIELD_W-1:0]  object_index = '0;
  logic [RATE_FIELD_W-1:0] rate_index = '0;
  logic [TICKS_W-1:0]      start_ticks = '0;
  logic [TICKS_W-1:0]      period_ticks = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [OBJ_FIELD_W-1:0]  expired_object;
  logic [RATE_FIELD_W-1:0] expired_rate;
  logic                    last;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  multi_rate_timeout_timer_bank DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .object_index(object_index), .rate_index(rate_index),
    .start_ticks(start_ticks), .period_ticks(period_ticks),
    .out_valid(out_valid), .out_stall(out_stall),
    .expired_object(expired_object), .expired_rate(expired_rate), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow timer bank
  bit [TICKS_W-1:0]     count_m  [1:OBJECTS][0:RATES-1];
  bit [TICKS_W-1:0]     period_m [1:OBJECTS][0:RATES-1];
  bit [OBJ_FIELD_W-1:0] walk_top = ACTIVE_COUNT_RESET;

  timer_item_t pending[$];
  expiry_t     due_expiries[$];
  timer_item_t cur;
  bit          steady = 1'b0;
  int          mismatches = 0;
  int          seen_results = 0;
  int          hold_left = 0;

  function automatic void apply_item(timer_item_t it);
    int top;
    int n0;
    expiry_t e;
    n0 = due_expiries.size();
    case (it.op)
      OP_TICK: begin
        top = (walk_top > OBJECTS) ? OBJECTS : int'(walk_top);
        for (int p = top; p >= 1; p--) begin
          if (count_m[p][it.rate] != 0) begin
            count_m[p][it.rate] = count_m[p][it.rate] - 1'b1;
            if (count_m[p][it.rate] == 0) begin
              count_m[p][it.rate] = period_m[p][it.rate];
              e.obj = OBJ_FIELD_W'(p);
              e.rate = it.rate;
              e.last = 1'b0;
              due_expiries.push_back(e);
            end
          end
        end
        if (due_expiries.size() > n0) due_expiries[due_expiries.size()-1].last = 1'b1;
      end
      OP_ARM: begin
        if (it.obj >= 1 && it.obj <= OBJECTS) begin
          count_m[it.obj][it.rate] = it.start;
          period_m[it.obj][it.rate] = it.period;
        end
      end
      OP_DISARM: begin
        if (it.obj >= 1 && it.obj <= OBJECTS) begin
          count_m[it.obj][it.rate] = '0;
          period_m[it.obj][it.rate] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) apply_item(cur);
      if (pending.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
        cur = pending.pop_front();
        in_valid <= 1'b1;
        op <= cur.op;
        object_index <= cur.obj;
        rate_index <= cur.rate;
        start_ticks <= cur.start;
        period_ticks <= cur.period;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    expiry_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_results++;
        // one long hold-off so the walk backs up and the input stalls
        if (seen_results == 60) hold_left = 300;
        if (due_expiries.size() == 0) begin
          $display("%0t: expiry object %0d rate %0d last %0b, none expected",
                   $time, expired_object, expired_rate, last);
          mismatches++;
        end else begin
          want = due_expiries.pop_front();
          if (expired_object !== want.obj || expired_rate !== want.rate ||
              last !== want.last) begin
            $display("%0t: expected object %0d rate %0d last %0b, got %0d %0d %0b",
                     $time, want.obj, want.rate, want.last,
                     expired_object, expired_rate, last);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 28);
      end
    end
  end

  task automatic push(input logic [OP_W-1:0] o, input int obj, input int rate,
                      input int start, input int period);
    timer_item_t it;
    it.op = o;
    it.obj = OBJ_FIELD_W'(obj);
    it.rate = RATE_FIELD_W'(rate);
    it.start = TICKS_W'(start);
    it.period = TICKS_W'(period);
    pending.push_back(it);
  endtask

  function automatic timer_item_t make_random_item(int span);
    timer_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.op = OP_TICK;
    it.obj = OBJ_FIELD_W'($urandom);
    it.rate = RATE_FIELD_W'($urandom);
    it.start = TICKS_W'($urandom);
    it.period = TICKS_W'($urandom);
    if (pick >= 40 && pick < 92) begin
      it.op = (pick < 78) ? OP_ARM : OP_DISARM;
      it.obj = OBJ_FIELD_W'(($urandom_range(99) < 80) ? $urandom_range(span, 1)
                                                       : $urandom_range(OBJECTS, 1));
      if ($urandom_range(99) < 88) it.start = TICKS_W'($urandom_range(4, 1));
      else if ($urandom_range(1) == 0) it.start = '0;
      if ($urandom_range(99) < 85) it.period = TICKS_W'($urandom_range(5));
    end else if (pick >= 92 && pick < 96) begin
      it.op = OP_NONE;
    end else if (pick >= 96) begin
      it.op = OP_ARM;
    end
    return it;
  endfunction

  task automatic settle();
    while (pending.size() != 0 || in_valid || due_expiries.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_active_count(input logic [OBJ_FIELD_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= APB_ADDR_W'({REG_ACTIVE_COUNT, 2'b00});
    pwdata <= {26'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    walk_top = value;
    @(negedge clk);
  endtask

  initial begin
    logic [OBJ_FIELD_W-1:0] cfg;
    int span;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push(OP_ARM, 32, 0, 1, 0);
    push(OP_ARM, 1, 0, 1, 2);
    push(OP_ARM, 16, 0, 0, 5);          // zero start stays disarmed
    push(OP_ARM, 0, 1, 1, 1);
    push(OP_ARM, 33, 1, 1, 1);
    push(OP_DISARM, 63, 1, 0, 0);
    push(OP_NONE, 5, 3, 1, 1);
    push(OP_ARM, 8, 3, 16'hFFFF, 16'hFFFF);
    push(OP_ARM, 2, 3, 1, 16'hFFFF);
    push(OP_ARM, 5, 1, 2, 1);
    push(OP_DISARM, 5, 1, 0, 0);
    push(OP_TICK, 0, 0, 0, 0);
    push(OP_TICK, 0, 0, 0, 0);
    push(OP_TICK, 0, 0, 0, 0);
    push(OP_TICK, 0, 1, 0, 0);
    push(OP_TICK, 0, 3, 0, 0);
    push(OP_TICK, 63, 2, 16'hFFFF, 16'hFFFF);
    settle();

    set_active_count(6'd1);
    push(OP_ARM, 1, 0, 1, 1);
    push(OP_ARM, 2, 0, 1, 0);           // above the walk, not ticked
    push(OP_TICK, 0, 0, 0, 0);
    settle();
    set_active_count(6'd0);
    push(OP_TICK, 0, 0, 0, 0);
    settle();
    set_active_count(6'd63);
    push(OP_TICK, 0, 0, 0, 0);
    settle();
    set_active_count(6'd33);
    push(OP_TICK, 0, 0, 0, 0);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: cfg = 6'd32;
        1: cfg = 6'd3;
        2: cfg = 6'd63;
        3: cfg = OBJ_FIELD_W'($urandom_range(OBJECTS, 1));
        default: cfg = 6'd17;
      endcase
      set_active_count(cfg);
      span = (cfg == 0) ? 1 : ((cfg > OBJECTS) ? OBJECTS : int'(cfg));
      steady = (ph == 2);
      for (int i = 0; i < 50; i++) pending.push_back(make_random_item(span));
      settle();
      steady = 1'b0;
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/mrtt_pkg.sv
rtl/core/mrtt_ram.sv
rtl/core/mrtt_ctrl.sv
rtl/core/mrtt_dp.sv
rtl/core/multi_rate_timeout_timer_bank.sv
dv/multi_rate_timeout_timer_bank_tb.sv
